// ===== src/dstp_pkg.sv =====
// ----------------------------------------------------------------------------
// dstp_pkg
// Types and constants shared by the tone player sequencer and datapath.
// ----------------------------------------------------------------------------
package dstp_pkg;

    localparam int unsigned PC_BITS = 4;

    localparam logic [31:0] SIN_A     = 32'd51472;
    localparam logic [31:0] SIN_B     = 32'd21024;
    localparam logic [31:0] SIN_C     = 32'd2320;
    localparam logic [31:0] PEAK_AMPL = 32'd16000;
    localparam logic [16:0] ENV_FULL  = 17'd65536;
    localparam logic [8:0]  VOL_UNITY = 9'd256;
    localparam logic [8:0]  VOL_RESET = 9'd77;

    typedef enum logic [2:0] {
        UK_DISPATCH,
        UK_LOAD,
        UK_SILENT,
        UK_STOP,
        UK_MUL,
        UK_EMIT
    } t_kind;

    typedef enum logic [1:0] {
        SA_X,
        SA_X2,
        SA_ACC
    } t_sel_a;

    typedef enum logic [2:0] {
        SB_X,
        SB_X2,
        SB_C,
        SB_ENV,
        SB_PEAK,
        SB_VOL
    } t_sel_b;

    typedef enum logic [1:0] {
        PO_NONE,
        PO_SUB_A,
        PO_SUB_B
    } t_post;

    typedef struct packed {
        t_kind              kind;
        t_sel_a             sel_a;
        t_sel_b             sel_b;
        logic [4:0]         shift;
        t_post              post;
        logic               wr_x2;
        logic [PC_BITS-1:0] next;
    } t_uop;

    typedef struct packed {
        logic fire;
        t_uop uop;
    } t_ctrl;

    typedef struct packed {
        logic trig;
        logic playing;
        logic active;
        logic out_full;
    } t_stat;

endpackage

// ===== src/dstp_seq.sv =====
// ----------------------------------------------------------------------------
// dstp_seq
// Step counter and control store: dispatches each item and walks the program.
// ----------------------------------------------------------------------------
module dstp_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dstp_pkg::t_stat i_stat,
    output dstp_pkg::t_ctrl o_ctrl
);

    localparam logic [dstp_pkg::PC_BITS-1:0] PC_DISPATCH = 4'd0;
    localparam logic [dstp_pkg::PC_BITS-1:0] PC_LOAD     = 4'd1;
    localparam logic [dstp_pkg::PC_BITS-1:0] PC_SILENT   = 4'd2;
    localparam logic [dstp_pkg::PC_BITS-1:0] PC_STOP     = 4'd3;
    localparam logic [dstp_pkg::PC_BITS-1:0] PC_MUL0     = 4'd4;
    localparam logic [dstp_pkg::PC_BITS-1:0] PC_POLY_C   = 4'd5;
    localparam logic [dstp_pkg::PC_BITS-1:0] PC_POLY_B   = 4'd6;
    localparam logic [dstp_pkg::PC_BITS-1:0] PC_SINE     = 4'd7;
    localparam logic [dstp_pkg::PC_BITS-1:0] PC_ENV      = 4'd8;
    localparam logic [dstp_pkg::PC_BITS-1:0] PC_PEAK     = 4'd9;
    localparam logic [dstp_pkg::PC_BITS-1:0] PC_VOL      = 4'd10;
    localparam logic [dstp_pkg::PC_BITS-1:0] PC_EMIT     = 4'd11;

    function automatic dstp_pkg::t_uop rom(input logic [dstp_pkg::PC_BITS-1:0] pc);
        dstp_pkg::t_uop u;
        u.kind  = dstp_pkg::UK_MUL;
        u.sel_a = dstp_pkg::SA_ACC;
        u.sel_b = dstp_pkg::SB_X;
        u.shift = 5'd15;
        u.post  = dstp_pkg::PO_NONE;
        u.wr_x2 = 1'b0;
        u.next  = pc + 4'd1;
        unique case (pc)
            PC_DISPATCH: u.kind = dstp_pkg::UK_DISPATCH;
            PC_LOAD:     u.kind = dstp_pkg::UK_LOAD;
            PC_SILENT:   u.kind = dstp_pkg::UK_SILENT;
            PC_STOP:     u.kind = dstp_pkg::UK_STOP;
            PC_MUL0: begin
                u.sel_a = dstp_pkg::SA_X;
                u.wr_x2 = 1'b1;
            end
            PC_POLY_C: begin
                u.sel_a = dstp_pkg::SA_X2;
                u.sel_b = dstp_pkg::SB_C;
                u.post  = dstp_pkg::PO_SUB_B;
            end
            PC_POLY_B: begin
                u.sel_b = dstp_pkg::SB_X2;
                u.post  = dstp_pkg::PO_SUB_A;
            end
            PC_SINE:     u.sel_b = dstp_pkg::SB_X;
            PC_ENV: begin
                u.sel_b = dstp_pkg::SB_ENV;
                u.shift = 5'd0;
            end
            PC_PEAK: begin
                u.sel_b = dstp_pkg::SB_PEAK;
                u.shift = 5'd31;
            end
            PC_VOL: begin
                u.sel_b = dstp_pkg::SB_VOL;
                u.shift = 5'd8;
            end
            PC_EMIT:     u.kind = dstp_pkg::UK_EMIT;
            default: begin
                u.kind = dstp_pkg::UK_SILENT;
                u.next = PC_DISPATCH;
            end
        endcase
        return u;
    endfunction

    logic                         r_busy;
    logic [dstp_pkg::PC_BITS-1:0] r_pc;
    logic                         n_busy;
    logic [dstp_pkg::PC_BITS-1:0] n_pc;
    dstp_pkg::t_uop               uop;
    logic                         emits;
    logic                         stall;

    assign uop     = rom(r_pc);
    assign emits   = (uop.kind == dstp_pkg::UK_SILENT) || (uop.kind == dstp_pkg::UK_STOP) ||
                     (uop.kind == dstp_pkg::UK_EMIT);
    assign stall   = emits && i_stat.out_full;
    assign o_ready = !r_busy;

    assign o_ctrl.fire = r_busy && !stall;
    assign o_ctrl.uop  = uop;

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (!r_busy) begin
            if (i_valid) begin
                n_busy = 1'b1;
                n_pc   = PC_DISPATCH;
            end
        end else if (!stall) begin
            unique case (uop.kind)
                dstp_pkg::UK_DISPATCH: begin
                    if (i_stat.trig) begin
                        n_pc = PC_LOAD;
                    end else if (!i_stat.playing) begin
                        n_pc = PC_SILENT;
                    end else if (!i_stat.active) begin
                        n_pc = PC_STOP;
                    end else begin
                        n_pc = PC_MUL0;
                    end
                end
                dstp_pkg::UK_MUL: n_pc = uop.next;
                default: begin
                    n_busy = 1'b0;
                    n_pc   = PC_DISPATCH;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= PC_DISPATCH;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    a_pc_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_pc <= PC_EMIT)
        else $error("step counter left the program");

    a_start_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_busy && r_pc == PC_DISPATCH))
        else $error("accepted item did not start at dispatch");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && stall) |=> (r_busy && $stable(r_pc)))
        else $error("output step not held while result waits");

    a_idle_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_pc == PC_DISPATCH)
        else $error("idle sequencer away from dispatch");

endmodule

// ===== src/dstp_dp.sv =====
// ----------------------------------------------------------------------------
// dstp_dp
// Tone state, shared multiplier with shift and subtract, and result register.
// ----------------------------------------------------------------------------
module dstp_dp #(
    parameter int unsigned MAX_TONE_SAMPLES = 22050,
    parameter int unsigned SINE_TABLE_BITS  = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [8:0]         i_cfg_data,
    input  logic               i_accept,
    input  logic               i_op,
    input  logic [31:0]        i_phase_step,
    input  logic [14:0]        i_tone_length,
    input  logic [15:0]        i_decay_step,
    input  dstp_pkg::t_ctrl    i_ctrl,
    output dstp_pkg::t_stat    o_stat,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [14:0] o_sample,
    output logic               o_still_playing
);

    localparam logic [31:0] PHASE_KEEP = ~(32'hFFFF_FFFF >> SINE_TABLE_BITS);
    localparam logic [14:0] MAX_LEN    = 15'(MAX_TONE_SAMPLES);

    logic [8:0]  r_vol;
    logic [31:0] r_phase;
    logic [16:0] r_env;
    logic [14:0] r_index;
    logic [14:0] r_len;
    logic [31:0] r_step;
    logic [15:0] r_decay;
    logic        r_playing;
    logic        r_out_valid;
    logic        r_out_playing;
    logic signed [14:0] r_sample;

    logic        r_op;
    logic [31:0] r_in_step;
    logic [14:0] r_in_len;
    logic [15:0] r_in_decay;
    logic [31:0] r_acc;
    logic [15:0] r_x2;

    logic [31:0] fold;
    logic [15:0] x;
    logic        neg;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [63:0] shifted;
    logic [31:0] res;
    logic [8:0]  vol_sat;
    logic [14:0] mag;
    logic [14:0] n_sample;
    logic [16:0] n_env;
    logic [14:0] n_len;
    logic        emit_now;

    assign fold    = r_phase & PHASE_KEEP;
    assign x       = fold[30] ? (16'd32768 - {1'b0, fold[29:15]}) : {1'b0, fold[29:15]};
    assign neg     = fold[31];
    assign vol_sat = (r_vol > dstp_pkg::VOL_UNITY) ? dstp_pkg::VOL_UNITY : r_vol;

    always_comb begin
        case (i_ctrl.uop.sel_a)
            dstp_pkg::SA_X:  mul_a = {16'd0, x};
            dstp_pkg::SA_X2: mul_a = {16'd0, r_x2};
            default:         mul_a = r_acc;
        endcase
        case (i_ctrl.uop.sel_b)
            dstp_pkg::SB_X:    mul_b = {16'd0, x};
            dstp_pkg::SB_X2:   mul_b = {16'd0, r_x2};
            dstp_pkg::SB_C:    mul_b = dstp_pkg::SIN_C;
            dstp_pkg::SB_ENV:  mul_b = {15'd0, r_env};
            dstp_pkg::SB_PEAK: mul_b = dstp_pkg::PEAK_AMPL;
            default:           mul_b = {23'd0, vol_sat};
        endcase
    end

    assign prod    = {32'd0, mul_a} * {32'd0, mul_b};
    assign shifted = prod >> i_ctrl.uop.shift;

    always_comb begin
        case (i_ctrl.uop.post)
            dstp_pkg::PO_SUB_A: res = dstp_pkg::SIN_A - shifted[31:0];
            dstp_pkg::PO_SUB_B: res = dstp_pkg::SIN_B - shifted[31:0];
            default:            res = shifted[31:0];
        endcase
    end

    assign mag      = r_acc[14:0];
    assign n_sample = neg ? (~mag + 15'd1) : mag;
    assign n_env    = (r_env > {1'b0, r_decay}) ? (r_env - {1'b0, r_decay}) : 17'd0;
    assign n_len    = (r_in_len > MAX_LEN) ? MAX_LEN : r_in_len;
    assign emit_now = i_ctrl.fire && (i_ctrl.uop.kind inside {dstp_pkg::UK_SILENT,
                                                              dstp_pkg::UK_STOP,
                                                              dstp_pkg::UK_EMIT});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol         <= dstp_pkg::VOL_RESET;
            r_phase       <= '0;
            r_env         <= '0;
            r_index       <= '0;
            r_len         <= '0;
            r_step        <= '0;
            r_decay       <= '0;
            r_playing     <= 1'b0;
            r_out_valid   <= 1'b0;
            r_out_playing <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vol <= i_cfg_data;
            end
            if (emit_now) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_ctrl.fire) begin
                case (i_ctrl.uop.kind)
                    dstp_pkg::UK_LOAD: begin
                        r_step    <= r_in_step;
                        r_len     <= n_len;
                        r_decay   <= r_in_decay;
                        r_phase   <= '0;
                        r_env     <= dstp_pkg::ENV_FULL;
                        r_index   <= '0;
                        r_playing <= 1'b1;
                    end
                    dstp_pkg::UK_SILENT: begin
                        r_out_playing <= 1'b0;
                    end
                    dstp_pkg::UK_STOP: begin
                        r_playing     <= 1'b0;
                        r_out_playing <= 1'b0;
                    end
                    dstp_pkg::UK_EMIT: begin
                        r_index       <= r_index + 15'd1;
                        r_phase       <= r_phase + r_step;
                        r_env         <= n_env;
                        r_out_playing <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_op       <= i_op;
            r_in_step  <= i_phase_step;
            r_in_len   <= i_tone_length;
            r_in_decay <= i_decay_step;
        end
        if (i_ctrl.fire) begin
            case (i_ctrl.uop.kind) inside
                dstp_pkg::UK_MUL: begin
                    r_acc <= res;
                    if (i_ctrl.uop.wr_x2) begin
                        r_x2 <= res[15:0];
                    end
                end
                dstp_pkg::UK_SILENT, dstp_pkg::UK_STOP: r_sample <= '0;
                dstp_pkg::UK_EMIT:                     r_sample <= n_sample;
                default: ;
            endcase
        end
    end

    assign o_stat.trig     = r_op;
    assign o_stat.playing  = r_playing;
    assign o_stat.active   = r_index < r_len;
    assign o_stat.out_full = r_out_valid && !i_ready;

    assign o_valid         = r_out_valid;
    assign o_sample        = r_sample;
    assign o_still_playing = r_out_playing;

endmodule

// ===== src/decaying_sine_tone_player_unit.sv =====
// ----------------------------------------------------------------------------
// decaying_sine_tone_player_unit
// Sine tone generator with a linear envelope, run by a small control program.
//
// Input channel (i_valid / o_ready): i_op high triggers a tone with
// i_phase_step, i_tone_length (clamped to MAX_TONE_SAMPLES) and i_decay_step;
// i_op low is a tick that asks for one sample. A trigger gives no result.
// Output channel (o_valid / i_ready): one transfer per tick, o_sample and
// o_still_playing.
// i_cfg_we / i_cfg_data write the master volume (Q1.8, above 256 saturates).
// Steps: a trigger runs dispatch and load after its transfer; a silent or
// ending tick runs dispatch and its output step, its result showing in the
// cycle after; a playing tick runs dispatch, seven program steps on the
// shared 32x32 multiplier (sine polynomial, envelope, peak, volume) and
// output; result and o_ready return together. One item is in work at a time.
// A result waiting in the output register does not block the next transfer;
// a stalled receiver holds the program at its output step until taken.
// Reset: silent, volume 77, no result pending.
// ----------------------------------------------------------------------------
module decaying_sine_tone_player_unit #(
    parameter int unsigned MAX_TONE_SAMPLES = 22050,
    parameter int unsigned SINE_TABLE_BITS  = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [8:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_op,
    input  logic [31:0]        i_phase_step,
    input  logic [14:0]        i_tone_length,
    input  logic [15:0]        i_decay_step,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [14:0] o_sample,
    output logic               o_still_playing
);

    dstp_pkg::t_ctrl ctrl;
    dstp_pkg::t_stat stat;
    logic            accept;

    assign accept = i_valid && o_ready;

    dstp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    dstp_dp #(
        .MAX_TONE_SAMPLES (MAX_TONE_SAMPLES),
        .SINE_TABLE_BITS  (SINE_TABLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_accept        (accept),
        .i_op            (i_op),
        .i_phase_step    (i_phase_step),
        .i_tone_length   (i_tone_length),
        .i_decay_step    (i_decay_step),
        .i_ctrl          (ctrl),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_sample        (o_sample),
        .o_still_playing (o_still_playing)
    );

endmodule

// ===== dv/tone_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tone_tb_pkg
// Item codes shared by the tone player stimulus and its checker.
// ----------------------------------------------------------------------------
package tone_tb_pkg;

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_TRIGGER = 1'b1
    } t_tone_op;

endpackage

// ===== dv/tone_sample_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tone_sample_checker
// Watches the volume port and both channels of the tone player, keeps its own
// copy of the oscillator and envelope, predicts the sample of every tick and
// compares each output transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tone_sample_checker #(
    parameter int unsigned MAX_LEN    = 22050,
    parameter int unsigned TABLE_BITS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [8:0]         i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_op,
    input  logic [31:0]        i_phase_step,
    input  logic [14:0]        i_tone_length,
    input  logic [15:0]        i_decay_step,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [14:0] i_sample,
    input  logic               i_still_playing,
    output int                 o_fail_count,
    output int                 o_outstanding
);

    typedef struct packed {
        logic signed [14:0] sample;
        logic               still_playing;
    } t_tone_out;

    t_tone_out   expected_samples[$];
    t_tone_out   want;
    int          fail_count;

    logic [8:0]  gain_reg;
    logic [31:0] osc_phase;
    logic [31:0] osc_step;
    logic [16:0] env_level;
    logic [15:0] env_decay;
    logic [14:0] tone_idx;
    logic [14:0] tone_len;
    logic        tone_on;

    function automatic logic [31:0] sine_magnitude(input logic [31:0] phase,
                                                   output logic negative);
        logic [31:0] keep;
        logic [31:0] p;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        keep = 32'hFFFF_FFFF << (32 - TABLE_BITS);
        p = phase & keep;
        x = 64'(p[29:15]);
        if (p[30]) begin
            x = 64'd32768 - x;
        end
        negative = p[31];
        x2 = (x * x) >> 15;
        t  = (64'(dstp_pkg::SIN_C) * x2) >> 15;
        t  = 64'(dstp_pkg::SIN_B) - t;
        t  = (t * x2) >> 15;
        t  = 64'(dstp_pkg::SIN_A) - t;
        return 32'((t * x) >> 15);
    endfunction

    function t_tone_out next_tone_sample();
        t_tone_out   res;
        logic        neg;
        logic [31:0] mag;
        logic [8:0]  gain;
        logic [63:0] v;
        res.sample        = '0;
        res.still_playing = 1'b0;
        if (!tone_on) begin
            return res;
        end
        if (tone_idx < tone_len) begin
            mag  = sine_magnitude(osc_phase, neg);
            gain = (gain_reg > dstp_pkg::VOL_UNITY) ? dstp_pkg::VOL_UNITY : gain_reg;
            v = (64'(mag) * 64'(env_level) * 64'(dstp_pkg::PEAK_AMPL)) >> 31;
            v = (v * 64'(gain)) >> 8;
            res.sample        = neg ? -v[14:0] : v[14:0];
            res.still_playing = 1'b1;
            tone_idx  = tone_idx + 15'd1;
            osc_phase = osc_phase + osc_step;
            if (env_level > {1'b0, env_decay}) begin
                env_level = env_level - {1'b0, env_decay};
            end else begin
                env_level = '0;
            end
            return res;
        end
        tone_on = 1'b0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_samples.delete();
            fail_count = 0;
            gain_reg   = dstp_pkg::VOL_RESET;
            osc_phase  = '0;
            osc_step   = '0;
            env_level  = '0;
            env_decay  = '0;
            tone_idx   = '0;
            tone_len   = '0;
            tone_on    = 1'b0;
        end else begin
            if (i_cfg_we) begin
                gain_reg = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    $error("unexpected result transfer: sample %0d, still_playing %0d",
                           i_sample, i_still_playing);
                    fail_count++;
                end else begin
                    want = expected_samples.pop_front();
                    if (i_sample !== want.sample) begin
                        $error("sample mismatch: expected %0d, actual %0d",
                               want.sample, i_sample);
                        fail_count++;
                    end
                    if (i_still_playing !== want.still_playing) begin
                        $error("still_playing mismatch: expected %0d, actual %0d",
                               want.still_playing, i_still_playing);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_op == tone_tb_pkg::OP_TRIGGER) begin
                    osc_step  = i_phase_step;
                    tone_len  = (i_tone_length > MAX_LEN) ? 15'(MAX_LEN) : i_tone_length;
                    env_decay = i_decay_step;
                    osc_phase = '0;
                    env_level = dstp_pkg::ENV_FULL;
                    tone_idx  = '0;
                    tone_on   = 1'b1;
                end else begin
                    expected_samples.push_back(next_tone_sample());
                end
            end
        end
        o_outstanding <= expected_samples.size();
        o_fail_count  <= fail_count;
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the tone player with a short directed run and then with random
// tones at several volume settings, with random gaps on both channels and a
// long receiver hold-off; the checker beside the block judges every sample.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned MAX_LEN    = 22050;
    localparam int unsigned TABLE_BITS = 10;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_cfg_we        = 1'b0;
    logic [8:0]         i_cfg_data      = '0;
    logic               i_valid         = 1'b0;
    logic               o_ready;
    logic               i_op            = 1'b0;
    logic [31:0]        i_phase_step    = '0;
    logic [14:0]        i_tone_length   = '0;
    logic [15:0]        i_decay_step    = '0;
    logic               o_valid;
    logic               i_ready         = 1'b0;
    logic signed [14:0] o_sample;
    logic               o_still_playing;

    int fail_count;
    int outstanding;
    int items_sent   = 0;
    int results_seen = 0;

    decaying_sine_tone_player_unit #(
        .MAX_TONE_SAMPLES(MAX_LEN),
        .SINE_TABLE_BITS (TABLE_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_phase_step   (i_phase_step),
        .i_tone_length  (i_tone_length),
        .i_decay_step   (i_decay_step),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sample       (o_sample),
        .o_still_playing(o_still_playing)
    );

    tone_sample_checker #(
        .MAX_LEN   (MAX_LEN),
        .TABLE_BITS(TABLE_BITS)
    ) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_op           (i_op),
        .i_phase_step   (i_phase_step),
        .i_tone_length  (i_tone_length),
        .i_decay_step   (i_decay_step),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_sample       (o_sample),
        .i_still_playing(o_still_playing),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // receiver: random hold-off per result, a burst with none, two long stalls
    initial begin
        int wait_cycles;
        forever begin
            if (results_seen == 40 || results_seen == 420) begin
                wait_cycles = 300;
            end else if (results_seen >= 150 && results_seen < 250) begin
                wait_cycles = 0;
            end else begin
                wait_cycles = $urandom_range(0, 9);
            end
            if (wait_cycles > 0) begin
                i_ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
            results_seen++;
        end
    end

    task automatic offer_item(input tone_tb_pkg::t_tone_op op, input logic [31:0] step,
                              input logic [14:0] len, input logic [15:0] decay);
        int gap;
        if (items_sent >= 200 && items_sent < 320) begin
            gap = 0;
        end else begin
            gap = $urandom_range(0, 9);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_phase_step  <= step;
        i_tone_length <= len;
        i_decay_step  <= decay;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        items_sent++;
    endtask

    task automatic offer_tick();
        offer_item(tone_tb_pkg::OP_TICK, $urandom, 15'($urandom), 16'($urandom));
    endtask

    task automatic set_volume(input logic [8:0] vol);
        i_valid <= 1'b0;
        while (outstanding != 0) @(posedge i_clk);
        // let a trailing trigger finish
        repeat (12) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= vol;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic random_tone();
        int          kind;
        int          ticks;
        logic [14:0] len;
        logic [15:0] decay;
        kind = $urandom_range(0, 15);
        if (kind == 0) begin
            repeat ($urandom_range(1, 3)) offer_tick();
            return;
        end
        case ($urandom_range(0, 3))
            0: decay = 16'($urandom_range(0, 255));
            1: decay = 16'($urandom_range(0, 4095));
            2: decay = 16'($urandom);
            default: decay = 16'($urandom_range(2000, 8000));
        endcase
        if (kind == 1) begin
            len   = 15'($urandom);
            ticks = $urandom_range(1, 5);
        end else if (kind == 2) begin
            len   = '0;
            ticks = $urandom_range(1, 3);
        end else if (kind == 3) begin
            len   = 15'($urandom_range(2, 24));
            ticks = $urandom_range(0, int'(len) - 1);
        end else begin
            len   = 15'($urandom_range(1, 24));
            ticks = int'(len) + $urandom_range(1, 3);
        end
        offer_item(tone_tb_pkg::OP_TRIGGER, $urandom, len, decay);
        repeat (ticks) offer_tick();
    endtask

    initial begin
        logic [8:0] volumes[8];
        int         target;
        volumes = '{9'd0, 9'd511, 9'd1, 9'd300, 9'd77, 9'd0, 9'd256, 9'd128};
        volumes[5] = 9'($urandom);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_volume(9'd256);
        offer_tick();
        offer_item(tone_tb_pkg::OP_TRIGGER, 32'h4000_0000, 15'd3, 16'd0);
        repeat (5) offer_tick();
        offer_item(tone_tb_pkg::OP_TRIGGER, 32'hFFFF_FFFF, 15'd0, 16'hFFFF);
        repeat (2) offer_tick();
        offer_item(tone_tb_pkg::OP_TRIGGER, 32'h0123_4567, 15'h7FFF, 16'hFFFF);
        repeat (3) offer_tick();
        offer_item(tone_tb_pkg::OP_TRIGGER, 32'h1234_5678, 15'd5, 16'd1000);
        repeat (2) offer_tick();
        offer_item(tone_tb_pkg::OP_TRIGGER, 32'h8000_0000, 15'd2, 16'd30000);
        repeat (3) offer_tick();

        foreach (volumes[i]) begin
            set_volume(volumes[i]);
            target = items_sent + 65;
            while (items_sent < target) random_tone();
        end

        i_valid <= 1'b0;
        while (outstanding != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/dstp_pkg.sv
src/dstp_seq.sv
src/dstp_dp.sv
src/decaying_sine_tone_player_unit.sv
dv/tone_tb_pkg.sv
dv/tone_sample_checker.sv
dv/tb.sv
